/* hw/rtl/rpi_pkg.sv */
// rpi_pkg: widths, register indexes and record types of the ray / paraboloid core
// no dependencies; imported by every rpi module
package rpi_pkg;

  // coordinate and register widths
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 32;
  localparam int EPS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // quadratic terms: a = dx^2+dy^2, b = 2(ox dx + oy dy - r dz), c = ox^2+oy^2-2 r oz
  localparam int P_W  = 2 * COORD_W;   // one coordinate product
  localparam int A_W  = 2 * COORD_W;   // a is never negative
  localparam int B_W  = 2 * COORD_W + 2;
  localparam int C_W  = 2 * COORD_W + 2;
  localparam int X_W  = 2 * B_W;       // discriminant
  localparam int S_W  = X_W / 2;       // integer square root

  // division of (-b +- s) * 2^32 by 2a, or -c * 2^32 by b
  localparam int T_W    = 64;          // ray parameter, signed Q32.32
  localparam int T_FRAC = 32;
  localparam int N_W    = S_W + 2;     // signed numerator
  localparam int D_W    = B_W;         // signed denominator
  localparam int NM_W   = N_W - 1;     // numerator magnitude
  localparam int DM_W   = D_W - 1;     // denominator magnitude
  localparam int Q_W    = T_W + 1;     // quotient bits formed by the divider

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVATURE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 1'b1;

  localparam logic signed [RAD_W-1:0] CURVATURE_RST = 32'sd65536;
  localparam logic        [EPS_W-1:0] EPSILON_RST   = 32'd4295;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
  } rpi_ray_t;

  // ray plus its early verdicts
  typedef struct packed {
    rpi_ray_t ray;
    logic     miss;
    logic     lin;
  } rpi_tag_t;

  // what travels beside the square root
  typedef struct packed {
    rpi_tag_t                tag;
    logic        [A_W-1:0]   a;
    logic signed [B_W-1:0]   b;
    logic signed [C_W-1:0]   c;
  } rpi_sqside_t;

endpackage

/* hw/rtl/rpi_quad.sv */
// rpi_quad: six-stage front end, forms a, b, c and the discriminant of one ray
// depends on rpi_pkg
module rpi_quad (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  rpi_pkg::rpi_ray_t               ray,
  input  logic signed [rpi_pkg::RAD_W-1:0] radius,
  output logic                            out_valid,
  output logic [rpi_pkg::X_W-1:0]         radicand,
  output rpi_pkg::rpi_sqside_t            side
);
  import rpi_pkg::*;

  localparam int BL_W = 33;             // low part of |b|
  localparam int BH_W = B_W - 1 - BL_W;
  localparam int CL_W = 32;             // low part of |c|
  localparam int CH_W = C_W - 1 - CL_W;
  localparam int AL_W = 32;
  localparam int AH_W = A_W - AL_W;
  localparam int BSQ_W = 2 * (B_W - 1);
  localparam int AC_W  = A_W + C_W - 1;

  logic [5:0] v_r;

  // stage 1: coordinate products
  rpi_ray_t                     ray1_r;
  logic                         rz1_r;
  logic signed [P_W-1:0]        oxdx1_r, oydy1_r, dxdx1_r, dydy1_r, oxox1_r, oyoy1_r;
  logic signed [P_W-1:0]        rdz1_r, roz1_r;

  // stage 2..5 carry record
  rpi_sqside_t                  sd2_r, sd3_r, sd4_r, sd5_r;

  // stage 3
  logic [B_W-2:0]               babs3_r;
  logic [C_W-2:0]               cabs3_r;
  logic                         cneg3_r, cneg4_r, cneg5_r;

  // stage 4 partial products
  logic [2*BH_W-1:0]            hh4_r;
  logic [BH_W+BL_W-1:0]         hl4_r;
  logic [2*BL_W-1:0]            ll4_r;
  logic [AH_W+CH_W-1:0]         ahch4_r;
  logic [AH_W+CL_W-1:0]         ahcl4_r;
  logic [AL_W+CH_W-1:0]         alch4_r;
  logic [AL_W+CL_W-1:0]         alcl4_r;

  // stage 5 sums
  logic [BSQ_W-1:0]             bsq5_r;
  logic [AC_W-1:0]              ac5_r;

  // stage 6 outputs
  logic [X_W-1:0]               radicand_r;
  rpi_sqside_t                  side_r;

  logic [A_W-1:0]               a_nxt;
  logic signed [B_W-1:0]        b_nxt;
  logic signed [C_W-1:0]        c_nxt;
  logic [BH_W-1:0]              bh;
  logic [BL_W-1:0]              bl;
  logic [CH_W-1:0]              ch;
  logic [CL_W-1:0]              cl;
  logic [AH_W-1:0]              ah;
  logic [AL_W-1:0]              al;
  logic [X_W-1:0]               ac4x;
  logic signed [X_W-1:0]        dsc;
  rpi_sqside_t                  side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r  <= ray;
      rz1_r   <= (radius == '0);
      oxdx1_r <= ray.ox * ray.dx;
      oydy1_r <= ray.oy * ray.dy;
      dxdx1_r <= ray.dx * ray.dx;
      dydy1_r <= ray.dy * ray.dy;
      oxox1_r <= ray.ox * ray.ox;
      oyoy1_r <= ray.oy * ray.oy;
      rdz1_r  <= radius * ray.dz;
      roz1_r  <= radius * ray.oz;
    end
  end

  // stage 2: sums
  assign a_nxt = A_W'(dxdx1_r) + A_W'(dydy1_r);
  assign b_nxt = (B_W'(oxdx1_r) + B_W'(oydy1_r) - B_W'(rdz1_r)) <<< 1;
  assign c_nxt = C_W'(oxox1_r) + C_W'(oyoy1_r) - (C_W'(roz1_r) <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r.tag.ray  <= ray1_r;
      sd2_r.tag.miss <= rz1_r;
      sd2_r.tag.lin  <= 1'b0;
      sd2_r.a        <= a_nxt;
      sd2_r.b        <= b_nxt;
      sd2_r.c        <= c_nxt;
    end
  end

  // stage 3: magnitudes for the wide squares
  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r   <= sd2_r;
      babs3_r <= sd2_r.b[B_W-1] ? (B_W-1)'(-sd2_r.b) : sd2_r.b[B_W-2:0];
      cabs3_r <= sd2_r.c[C_W-1] ? (C_W-1)'(-sd2_r.c) : sd2_r.c[C_W-2:0];
      cneg3_r <= sd2_r.c[C_W-1];
    end
  end

  // stage 4: partial products of b^2 and a|c|
  assign bh = babs3_r[B_W-2:BL_W];
  assign bl = babs3_r[BL_W-1:0];
  assign ch = cabs3_r[C_W-2:CL_W];
  assign cl = cabs3_r[CL_W-1:0];
  assign ah = sd3_r.a[A_W-1:AL_W];
  assign al = sd3_r.a[AL_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r   <= sd3_r;
      cneg4_r <= cneg3_r;
      hh4_r   <= bh * bh;
      hl4_r   <= bh * bl;
      ll4_r   <= bl * bl;
      ahch4_r <= ah * ch;
      ahcl4_r <= ah * cl;
      alch4_r <= al * ch;
      alcl4_r <= al * cl;
    end
  end

  // stage 5: assemble b^2 and a|c|
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r   <= sd4_r;
      cneg5_r <= cneg4_r;
      bsq5_r  <= (BSQ_W'(hh4_r) << (2 * BL_W)) + (BSQ_W'(hl4_r) << (BL_W + 1))
                 + BSQ_W'(ll4_r);
      ac5_r   <= (AC_W'(ahch4_r) << (AL_W + CL_W))
                 + ((AC_W'(ahcl4_r) + AC_W'(alch4_r)) << AL_W) + AC_W'(alcl4_r);
    end
  end

  // stage 6: discriminant and early miss
  assign ac4x = X_W'(ac5_r) << 2;
  assign dsc  = cneg5_r ? $signed(X_W'(bsq5_r) + ac4x) : $signed(X_W'(bsq5_r) - ac4x);

  always_comb begin
    side_nxt         = sd5_r;
    side_nxt.tag.lin = (sd5_r.a == '0);
    if (sd5_r.a == '0) begin
      side_nxt.tag.miss = sd5_r.tag.miss | (sd5_r.b == '0);
    end else begin
      side_nxt.tag.miss = sd5_r.tag.miss | dsc[X_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radicand_r <= dsc[X_W-1] ? '0 : dsc;
      side_r     <= side_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign radicand  = radicand_r;
  assign side      = side_r;

endmodule

/* hw/rtl/rpi_sqrt.sv */
// rpi_sqrt: pipelined integer square root, one root bit per stage
// depends on rpi_pkg
module rpi_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [rpi_pkg::X_W-1:0]  radicand,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic [rpi_pkg::S_W-1:0]  root,
  output logic [SIDE_W-1:0]        side_out
);
  import rpi_pkg::*;

  logic [S_W-1:0]    v_r;
  logic [X_W-1:0]    x_r    [S_W];
  logic [X_W-1:0]    r_r    [S_W];
  logic [SIDE_W-1:0] side_r [S_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[S_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < S_W; k++) begin : g_stage
    localparam int I = S_W - 1 - k;
    localparam logic [X_W-1:0] BIT = X_W'(1) << (2 * I);
    logic [X_W-1:0]    x_in;
    logic [X_W-1:0]    r_in;
    logic [X_W-1:0]    trial;
    logic [SIDE_W-1:0] s_in;

    if (k == 0) begin : g_first
      assign x_in = radicand;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign r_in = r_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_in;
        if (x_in >= trial) begin
          x_r[k] <= x_in - trial;
          r_r[k] <= (r_in >> 1) + BIT;
        end else begin
          x_r[k] <= x_in;
          r_r[k] <= r_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[S_W-1];
  assign root      = r_r[S_W-1][S_W-1:0];
  assign side_out  = side_r[S_W-1];

endmodule

/* hw/rtl/rpi_div.sv */
// rpi_div: two-lane pipelined restoring divider, t = sat64(num * 2^32 / den)
// depends on rpi_pkg
module rpi_div #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [rpi_pkg::NM_W-1:0]         num_mag [2],
  input  logic [rpi_pkg::DM_W-1:0]         den_mag [2],
  input  logic                             neg     [2],
  input  logic [SIDE_W-1:0]                side_in,
  output logic                             out_valid,
  output logic signed [rpi_pkg::T_W-1:0]   t       [2],
  output logic [SIDE_W-1:0]                side_out
);
  import rpi_pkg::*;

  localparam int R_W  = NM_W + T_FRAC;   // scaled numerator
  localparam int DV_W = DM_W + Q_W;      // widest shifted divisor
  localparam int DEPTH = Q_W + 2;        // check, quotient bits, saturation
  localparam logic [Q_W-1:0] POS_LIM = Q_W'((65'd1 << (T_W - 1)) - 65'd1);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(65'd1 << (T_W - 1));
  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  logic [DEPTH-1:0]  v_r;
  logic [SIDE_W-1:0] side_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) side_r[k] <= side_in;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [R_W-1:0]   rem_r [Q_W+1];
    logic [DM_W-1:0]  den_r [Q_W+1];
    logic [Q_W-1:0]   q_r   [Q_W+1];
    logic             neg_r [Q_W+1];
    logic             ovf_r [Q_W+1];
    logic signed [T_W-1:0] t_r;
    logic [R_W-1:0]   n_scaled;
    logic             sat;
    logic [Q_W-1:0]   qv;

    // a quotient of 2^65 or more saturates whatever its sign
    assign n_scaled = {num_mag[l], {T_FRAC{1'b0}}};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0] <= n_scaled;
        den_r[0] <= den_mag[l];
        q_r[0]   <= '0;
        neg_r[0] <= neg[l];
        ovf_r[0] <= DV_W'(n_scaled) >= (DV_W'(den_mag[l]) << Q_W);
      end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_bit
      localparam int P = Q_W - k;
      logic [DV_W-1:0] dsh;
      logic            ge;

      assign dsh = DV_W'(den_r[k-1]) << P;
      assign ge  = DV_W'(rem_r[k-1]) >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_r[k-1] - R_W'(dsh) : rem_r[k-1];
          q_r[k]   <= q_r[k-1] | (Q_W'(ge) << P);
          den_r[k] <= den_r[k-1];
          neg_r[k] <= neg_r[k-1];
          ovf_r[k] <= ovf_r[k-1];
        end
      end
    end

    assign qv  = q_r[Q_W];
    assign sat = ovf_r[Q_W] | (neg_r[Q_W] ? (qv > NEG_LIM) : (qv > POS_LIM));

    always_ff @(posedge clk) begin
      if (en) begin
        if (sat) begin
          t_r <= neg_r[Q_W] ? T_MIN : T_MAX;
        end else begin
          t_r <= neg_r[Q_W] ? -$signed(T_W'(qv)) : $signed(T_W'(qv));
        end
      end
    end

    assign t[l] = t_r;
  end

  assign out_valid = v_r[DEPTH-1];
  assign side_out  = side_r[DEPTH-1];

endmodule

/* hw/rtl/ray_parabola_intersect_core.sv */
// ray_parabola_intersect_core: top level of the ray / paraboloid intersection pipeline
// depends on rpi_pkg, rpi_quad, rpi_sqrt, rpi_div
//
//   port group   direction  handshake             contents
//   in_*         input      in_valid / in_stall   ray origin and direction, Q16.16
//   out_*        output     out_valid / out_stall hit flag and hit point, Q16.16
//   cfg_*        input      cfg_wr_en             curvature radius, root epsilon
//
// one ray enters per clock while in_stall is low; each ray passes through
// 6 front-end stages, 66 square-root stages, 2 operand stages, 67 divider stages
// and 3 back-end stages; the square root and divider each resolve one bit per stage
// rst_n is synchronous, clears every valid bit and resets the two config registers
// the whole pipeline advances together: it holds only while the output register is
// full and out_stall is high, and in_stall is raised for exactly those cycles
module ray_parabola_intersect_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // ray input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_origin_x,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_origin_y,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_origin_z,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_dir_x,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_dir_y,
  input  logic signed [rpi_pkg::COORD_W-1:0]    in_dir_z,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic signed [rpi_pkg::COORD_W-1:0]    out_hit_x,
  output logic signed [rpi_pkg::COORD_W-1:0]    out_hit_y,
  output logic signed [rpi_pkg::COORD_W-1:0]    out_hit_z,
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [rpi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rpi_pkg::CFG_W-1:0]             cfg_wdata
);
  import rpi_pkg::*;

  localparam int SQS_W = $bits(rpi_sqside_t);
  localparam int TAG_W = $bits(rpi_tag_t);
  localparam int PL_W  = COORD_W + T_FRAC + 1;   // d times the low half of t
  localparam int E_W   = P_W + 2;                // hit point before saturation
  localparam logic signed [E_W-1:0] CO_MAX = E_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [E_W-1:0] CO_MIN = -CO_MAX - E_W'(1);

  // global advance: everything moves unless a finished result is held
  logic en;

  // configuration registers
  logic signed [RAD_W-1:0] curv_r;
  logic [EPS_W-1:0]        eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curv_r <= CURVATURE_RST;
      eps_r  <= EPSILON_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CURVATURE: curv_r <= $signed(cfg_wdata[RAD_W-1:0]);
        REG_EPSILON:   eps_r  <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: quadratic terms and discriminant
  rpi_ray_t    in_ray;
  logic        q_valid;
  logic [X_W-1:0] q_radicand;
  rpi_sqside_t q_side;

  assign in_ray.ox = in_origin_x;
  assign in_ray.oy = in_origin_y;
  assign in_ray.oz = in_origin_z;
  assign in_ray.dx = in_dir_x;
  assign in_ray.dy = in_dir_y;
  assign in_ray.dz = in_dir_z;

  rpi_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .ray       (in_ray),
    .radius    (curv_r),
    .out_valid (q_valid),
    .radicand  (q_radicand),
    .side      (q_side)
  );

  // square root of the discriminant
  logic              s_valid;
  logic [S_W-1:0]    s_root;
  logic [SQS_W-1:0]  s_side_bits;
  rpi_sqside_t       s_side;

  rpi_sqrt #(
    .SIDE_W (SQS_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .radicand  (q_radicand),
    .side_in   (q_side),
    .out_valid (s_valid),
    .root      (s_root),
    .side_out  (s_side_bits)
  );

  assign s_side = rpi_sqside_t'(s_side_bits);

  // operand stage 1: signed numerators and denominators
  // lane 0 takes (-b + s) / 2a, or -c / b when a is zero; lane 1 takes (-b - s) / 2a
  logic                  vf1_r;
  rpi_tag_t              tagf1_r;
  logic signed [N_W-1:0] num1_r [2];
  logic signed [D_W-1:0] den1_r [2];
  logic signed [N_W-1:0] nb;
  logic signed [N_W-1:0] sx;
  logic signed [D_W-1:0] twoa;

  assign nb   = -N_W'(s_side.b);
  assign sx   = $signed({2'b00, s_root});
  assign twoa = $signed({1'b0, s_side.a, 1'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      tagf1_r <= s_side.tag;
      if (s_side.tag.lin) begin
        num1_r[0] <= -N_W'(s_side.c);
        den1_r[0] <= s_side.b;
      end else begin
        num1_r[0] <= nb + sx;
        den1_r[0] <= twoa;
      end
      num1_r[1] <= nb - sx;
      den1_r[1] <= twoa;
    end
  end

  // operand stage 2: sign and magnitude for the divider
  logic             vf2_r;
  rpi_tag_t         tagf2_r;
  logic [NM_W-1:0]  nmag2_r [2];
  logic [DM_W-1:0]  dmag2_r [2];
  logic             neg2_r  [2];

  for (genvar l = 0; l < 2; l++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en) begin
        nmag2_r[l] <= num1_r[l][N_W-1] ? NM_W'(-num1_r[l]) : num1_r[l][NM_W-1:0];
        dmag2_r[l] <= den1_r[l][D_W-1] ? DM_W'(-den1_r[l]) : den1_r[l][DM_W-1:0];
        neg2_r[l]  <= num1_r[l][N_W-1] ^ den1_r[l][D_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tagf2_r <= tagf1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
      vf2_r <= 1'b0;
    end else if (en) begin
      vf1_r <= s_valid;
      vf2_r <= vf1_r;
    end
  end

  // both roots divided in parallel
  logic                  d_valid;
  logic signed [T_W-1:0] d_t [2];
  logic [TAG_W-1:0]      d_tag_bits;
  rpi_tag_t              d_tag;

  rpi_div #(
    .SIDE_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vf2_r),
    .num_mag   (nmag2_r),
    .den_mag   (dmag2_r),
    .neg       (neg2_r),
    .side_in   (tagf2_r),
    .out_valid (d_valid),
    .t         (d_t),
    .side_out  (d_tag_bits)
  );

  assign d_tag = rpi_tag_t'(d_tag_bits);

  // root choice: smaller root above epsilon, or the linear root if positive
  logic                  vg_r;
  rpi_ray_t              rayg_r;
  logic                  hitg_r;
  logic signed [T_W-1:0] tg_r;
  logic signed [T_W-1:0] eps_t;
  logic                  hit_nxt;
  logic signed [T_W-1:0] t_nxt;

  assign eps_t = $signed(T_W'(eps_r));

  always_comb begin
    t_nxt   = d_t[0];
    hit_nxt = 1'b0;
    if (d_tag.lin) begin
      // strictly positive: sign clear and not zero
      hit_nxt = !d_t[0][T_W-1] && (d_t[0] != '0);
    end else if (d_t[1] > eps_t) begin
      t_nxt   = d_t[1];
      hit_nxt = 1'b1;
    end else begin
      hit_nxt = d_t[0] > eps_t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rayg_r <= d_tag.ray;
      hitg_r <= hit_nxt & ~d_tag.miss;
      tg_r   <= t_nxt;
    end
  end

  // hit point products: d * t split at the binary point of t
  logic                   vh_r;
  logic                   hith_r;
  logic signed [COORD_W-1:0] oh_r [3];
  logic signed [P_W-1:0]  ph_r [3];
  logic signed [PL_W-1:0] pl_r [3];
  logic signed [COORD_W-1:0] dg [3];
  logic signed [COORD_W-1:0] og [3];
  logic signed [T_W-T_FRAC-1:0] th;
  logic signed [T_FRAC:0]       tl;

  assign dg[0] = rayg_r.dx;
  assign dg[1] = rayg_r.dy;
  assign dg[2] = rayg_r.dz;
  assign og[0] = rayg_r.ox;
  assign og[1] = rayg_r.oy;
  assign og[2] = rayg_r.oz;
  assign th    = tg_r[T_W-1:T_FRAC];
  assign tl    = $signed({1'b0, tg_r[T_FRAC-1:0]});

  // final stage: floor(d t) + o, saturated; zeros on a miss
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic signed [COORD_W-1:0] out_pt_r [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [E_W-1:0] sum;

    always_ff @(posedge clk) begin
      if (en) begin
        ph_r[k] <= dg[k] * th;
        pl_r[k] <= dg[k] * tl;
        oh_r[k] <= og[k];
      end
    end

    assign sum = E_W'(ph_r[k]) + E_W'(pl_r[k] >>> T_FRAC) + E_W'(oh_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!hith_r) begin
          out_pt_r[k] <= '0;
        end else if (sum > CO_MAX) begin
          out_pt_r[k] <= CO_MAX[COORD_W-1:0];
        end else if (sum < CO_MIN) begin
          out_pt_r[k] <= CO_MIN[COORD_W-1:0];
        end else begin
          out_pt_r[k] <= sum[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hith_r    <= hitg_r;
      out_hit_r <= hith_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r        <= 1'b0;
      vh_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vg_r        <= d_valid;
      vh_r        <= vg_r;
      out_valid_r <= vh_r;
    end
  end

  assign en        = ~out_valid_r | ~out_stall;
  assign in_stall  = ~en;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_hit_x = out_pt_r[0];
  assign out_hit_y = out_pt_r[1];
  assign out_hit_z = out_pt_r[2];

endmodule
